// ----- hw/rtl/ftms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftms_pkg
// Shared types, constants and width helpers for the four-trait mean and
// standard deviation block.
// ----------------------------------------------------------------------------
package ftms_pkg;

  localparam int FIELD_W        = 16;
  localparam int N_TRAITS       = 4;
  localparam int TRAIT_IDX_W    = $clog2(N_TRAITS);
  localparam int MAX_ITEMS_DEF  = 4096;
  localparam int TRAIT_BITS_DEF = 16;

  // Effective trait width: the low TRAIT_BITS bits of a 16-bit field.
  function automatic int x_width(input int trait_bits);
    return (trait_bits < FIELD_W) ? trait_bits : FIELD_W;
  endfunction

  // Record counter width, wide enough to hold the maximum count itself.
  function automatic int cnt_width(input int max_items);
    return $clog2(max_items + 1);
  endfunction

  typedef struct packed {
    logic [FIELD_W-1:0] trait_mut_a;
    logic [FIELD_W-1:0] trait_mut_b;
    logic [FIELD_W-1:0] trait_switch;
    logic [FIELD_W-1:0] trait_env;
    logic               last_record;
  } rec_t;

  typedef struct packed {
    logic [FIELD_W-1:0] mean_mut_a;
    logic [FIELD_W-1:0] sd_mut_a;
    logic [FIELD_W-1:0] mean_mut_b;
    logic [FIELD_W-1:0] sd_mut_b;
    logic [FIELD_W-1:0] mean_switch;
    logic [FIELD_W-1:0] sd_switch;
    logic [FIELD_W-1:0] mean_env;
    logic [FIELD_W-1:0] sd_env;
    logic               overflowed;
  } res_t;

  typedef enum logic [3:0] {
    S_ACCUM,
    S_LD_NQ,
    S_MUL_NQ,
    S_LD_SS,
    S_MUL_SS,
    S_DIV,
    S_LD_ROOT,
    S_ROOT,
    S_STORE,
    S_DONE
  } ftms_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LD_NQ,
    OP_MUL_ADD,
    OP_LD_SS,
    OP_MUL_SUB,
    OP_DIV,
    OP_LD_ROOT,
    OP_ROOT,
    OP_STORE
  } dp_op_t;

  typedef struct packed {
    dp_op_t                 op;
    logic [TRAIT_IDX_W-1:0] trait;
    logic                   accum;
    logic                   load_out;
  } ftms_cmd_t;

endpackage

// ----- hw/rtl/four_trait_mean_and_std_dev.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_trait_mean_and_std_dev
// Population mean and standard deviation of four Q0.16 traits.
// ----------------------------------------------------------------------------
// Records are taken one per cycle while the block accumulates; each adds its
// four traits to running sums and sums of squares. Records beyond MAX_ITEMS
// are dropped and flag the result. The record that carries last_record
// closes the population: input then stalls while one shared shift-add
// multiplier, restoring divider and digit-by-digit root unit walk the four
// traits in turn (multiply, multiply-subtract, divide, root and mean divide,
// store), on X_W = min(TRAIT_BITS,16) bits with CNT_W = clog2(MAX_ITEMS+1)
// and SUM_W = X_W + CNT_W. The result beat then sits in an output register
// while the next population is already accepted.
// ----------------------------------------------------------------------------
module four_trait_mean_and_std_dev #(
  parameter int MAX_ITEMS  = ftms_pkg::MAX_ITEMS_DEF,
  parameter int TRAIT_BITS = ftms_pkg::TRAIT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           rec_valid,
  output logic           rec_ready,
  input  ftms_pkg::rec_t rec_data,
  output logic           res_valid,
  input  logic           res_ready,
  output ftms_pkg::res_t res_data
);

  ftms_pkg::ftms_cmd_t cmd;

  ftms_ctrl #(
    .MAX_ITEMS  (MAX_ITEMS),
    .TRAIT_BITS (TRAIT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_last  (rec_data.last_record),
    .rec_ready (rec_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .cmd       (cmd)
  );

  ftms_dp #(
    .MAX_ITEMS  (MAX_ITEMS),
    .TRAIT_BITS (TRAIT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rec_data (rec_data),
    .res_data (res_data)
  );

endmodule

// ----- hw/rtl/ftms_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftms_ctrl
// Sequencer: takes records, then walks each trait through multiply,
// divide and root phases and hands the result to the output register.
// ----------------------------------------------------------------------------
module ftms_ctrl #(
  parameter int MAX_ITEMS  = ftms_pkg::MAX_ITEMS_DEF,
  parameter int TRAIT_BITS = ftms_pkg::TRAIT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rec_valid,
  input  logic                rec_last,
  output logic                rec_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output ftms_pkg::ftms_cmd_t cmd
);

  localparam int X_W    = ftms_pkg::x_width(TRAIT_BITS);
  localparam int CNT_W  = ftms_pkg::cnt_width(MAX_ITEMS);
  localparam int SUM_W  = X_W + CNT_W;
  localparam int Q_W    = 2 * X_W;
  localparam int MAXS   = (SUM_W > Q_W) ? SUM_W : Q_W;
  localparam int STEP_W = $clog2(MAXS);

  localparam logic [STEP_W-1:0] LAST_NQ   = STEP_W'(CNT_W - 1);
  localparam logic [STEP_W-1:0] LAST_SS   = STEP_W'(SUM_W - 1);
  localparam logic [STEP_W-1:0] LAST_DIV  = STEP_W'(Q_W - 1);
  localparam logic [STEP_W-1:0] LAST_ROOT = STEP_W'(X_W - 1);
  localparam logic [ftms_pkg::TRAIT_IDX_W-1:0] LAST_TRAIT =
    ftms_pkg::TRAIT_IDX_W'(ftms_pkg::N_TRAITS - 1);

  ftms_pkg::ftms_state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic [ftms_pkg::TRAIT_IDX_W-1:0] trait, trait_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ftms_pkg::S_ACCUM;
      step      <= '0;
      trait     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      trait <= trait_next;
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    trait_next   = trait;
    rec_ready    = 1'b0;
    cmd.op       = ftms_pkg::OP_NONE;
    cmd.trait    = trait;
    cmd.accum    = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      ftms_pkg::S_ACCUM: begin
        rec_ready = 1'b1;
        cmd.accum = rec_valid;
        if (rec_valid && rec_last) begin
          trait_next = '0;
          state_next = ftms_pkg::S_LD_NQ;
        end
      end
      ftms_pkg::S_LD_NQ: begin
        cmd.op     = ftms_pkg::OP_LD_NQ;
        step_next  = '0;
        state_next = ftms_pkg::S_MUL_NQ;
      end
      ftms_pkg::S_MUL_NQ: begin
        cmd.op = ftms_pkg::OP_MUL_ADD;
        if (step == LAST_NQ) begin
          step_next  = '0;
          state_next = ftms_pkg::S_LD_SS;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ftms_pkg::S_LD_SS: begin
        cmd.op     = ftms_pkg::OP_LD_SS;
        state_next = ftms_pkg::S_MUL_SS;
      end
      ftms_pkg::S_MUL_SS: begin
        cmd.op = ftms_pkg::OP_MUL_SUB;
        if (step == LAST_SS) begin
          step_next  = '0;
          state_next = ftms_pkg::S_DIV;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ftms_pkg::S_DIV: begin
        cmd.op = ftms_pkg::OP_DIV;
        if (step == LAST_DIV) begin
          step_next  = '0;
          state_next = ftms_pkg::S_LD_ROOT;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ftms_pkg::S_LD_ROOT: begin
        cmd.op     = ftms_pkg::OP_LD_ROOT;
        state_next = ftms_pkg::S_ROOT;
      end
      ftms_pkg::S_ROOT: begin
        cmd.op = ftms_pkg::OP_ROOT;
        if (step == LAST_ROOT) begin
          step_next  = '0;
          state_next = ftms_pkg::S_STORE;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ftms_pkg::S_STORE: begin
        cmd.op = ftms_pkg::OP_STORE;
        if (trait == LAST_TRAIT) begin
          state_next = ftms_pkg::S_DONE;
        end else begin
          trait_next = trait + ftms_pkg::TRAIT_IDX_W'(1);
          state_next = ftms_pkg::S_LD_NQ;
        end
      end
      ftms_pkg::S_DONE: begin
        // hold until the output register is free
        if (!res_valid || res_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ftms_pkg::S_ACCUM;
        end
      end
      default: begin
        state_next = ftms_pkg::S_ACCUM;
      end
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!res_valid || res_ready))
    else $error("result loaded over a pending beat");

  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && rec_ready && rec_last) |=> !rec_ready)
    else $error("input still open after last record");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> res_valid)
    else $error("loaded result not presented");

endmodule

// ----- hw/rtl/ftms_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftms_dp
// Accumulators, shift-add multiplier, restoring divider, digit-by-digit
// square root, mean divider and the output register.
// ----------------------------------------------------------------------------
module ftms_dp #(
  parameter int MAX_ITEMS  = ftms_pkg::MAX_ITEMS_DEF,
  parameter int TRAIT_BITS = ftms_pkg::TRAIT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ftms_pkg::ftms_cmd_t cmd,
  input  ftms_pkg::rec_t      rec_data,
  output ftms_pkg::res_t      res_data
);

  localparam int X_W   = ftms_pkg::x_width(TRAIT_BITS);
  localparam int CNT_W = ftms_pkg::cnt_width(MAX_ITEMS);
  localparam int SUM_W = X_W + CNT_W;
  localparam int SQ_W  = 2 * X_W + CNT_W;
  localparam int NN_W  = 2 * CNT_W;
  localparam int Q_W   = 2 * X_W;
  localparam int NUM_W = NN_W + Q_W;
  localparam int NT    = ftms_pkg::N_TRAITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

  logic [CNT_W-1:0] count;
  logic             overflow_flag;
  logic [SUM_W-1:0] trait_sum [NT];
  logic [SQ_W-1:0]  trait_sum_sq [NT];
  logic [NN_W-1:0]  nn;

  logic [X_W-1:0]   x   [NT];
  logic [Q_W-1:0]   sqr [NT];
  logic             full;

  always_comb begin
    x[0] = rec_data.trait_mut_a[X_W-1:0];
    x[1] = rec_data.trait_mut_b[X_W-1:0];
    x[2] = rec_data.trait_switch[X_W-1:0];
    x[3] = rec_data.trait_env[X_W-1:0];
    for (int t = 0; t < NT; t++) begin
      sqr[t] = Q_W'(x[t]) * Q_W'(x[t]);
    end
    full = (count >= MAX_CNT);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      count         <= '0;
      overflow_flag <= 1'b0;
      for (int t = 0; t < NT; t++) begin
        trait_sum[t]    <= '0;
        trait_sum_sq[t] <= '0;
      end
    end else if (cmd.accum) begin
      if (full) begin
        // drop the record, remember it
        overflow_flag <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
        for (int t = 0; t < NT; t++) begin
          trait_sum[t]    <= trait_sum[t] + SUM_W'(x[t]);
          trait_sum_sq[t] <= trait_sum_sq[t] + SQ_W'(sqr[t]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    nn <= NN_W'(count) * NN_W'(count);
  end

  // Compute path
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] mc;
  logic [SUM_W-1:0] mp;
  logic [SUM_W-1:0] cur_sum;
  logic [SQ_W-1:0]  cur_sq;

  logic [NN_W-1:0]  div_hi;
  logic [NN_W:0]    div_r2;
  logic [NN_W:0]    div_diff;
  logic             div_ge;
  logic [NN_W-1:0]  div_rem;

  logic [X_W:0]     rt_rem;
  logic [X_W-1:0]   root;
  logic [X_W+2:0]   rt_sh;
  logic [X_W+2:0]   rt_trial;
  logic [X_W+2:0]   rt_diff;
  logic             rt_ge;

  logic [SUM_W-1:0] mdiv;
  logic [CNT_W:0]   md_r2;
  logic [CNT_W:0]   md_diff;
  logic             md_ge;

  logic [X_W-1:0]   mean_q [NT];
  logic [X_W-1:0]   sd_q   [NT];

  always_comb begin
    cur_sum = trait_sum[cmd.trait];
    cur_sq  = trait_sum_sq[cmd.trait];

    div_hi   = num[NUM_W-1:Q_W];
    div_r2   = {div_hi, num[Q_W-1]};
    div_diff = div_r2 - {1'b0, nn};
    div_ge   = (div_r2 >= {1'b0, nn});
    div_rem  = div_ge ? div_diff[NN_W-1:0] : div_r2[NN_W-1:0];

    rt_sh    = {rt_rem, num[Q_W-1:Q_W-2]};
    rt_trial = {1'b0, root, 2'b01};
    rt_diff  = rt_sh - rt_trial;
    rt_ge    = (rt_sh >= rt_trial);

    md_r2   = {mdiv[SUM_W-1:X_W], mdiv[X_W-1]};
    md_diff = md_r2 - {1'b0, count};
    md_ge   = (md_r2 >= {1'b0, count});
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ftms_pkg::OP_LD_NQ: begin
        num <= '0;
        mc  <= NUM_W'(cur_sq);
        mp  <= SUM_W'(count);
      end
      ftms_pkg::OP_MUL_ADD: begin
        if (mp[0]) begin
          num <= num + mc;
        end
        mc <= mc << 1;
        mp <= mp >> 1;
      end
      ftms_pkg::OP_LD_SS: begin
        mc <= NUM_W'(cur_sum);
        mp <= cur_sum;
      end
      ftms_pkg::OP_MUL_SUB: begin
        // partial differences never go below the final one, which is >= 0
        if (mp[0]) begin
          num <= num - mc;
        end
        mc <= mc << 1;
        mp <= mp >> 1;
      end
      ftms_pkg::OP_DIV: begin
        num <= {div_rem, num[Q_W-2:0], div_ge};
      end
      ftms_pkg::OP_LD_ROOT: begin
        rt_rem <= '0;
        root   <= '0;
        mdiv   <= cur_sum;
      end
      ftms_pkg::OP_ROOT: begin
        // advance the root and the mean divider together
        num    <= num << 2;
        rt_rem <= rt_ge ? rt_diff[X_W:0] : rt_sh[X_W:0];
        root   <= {root[X_W-2:0], rt_ge};
        mdiv   <= {(md_ge ? md_diff[CNT_W-1:0] : md_r2[CNT_W-1:0]),
                   mdiv[X_W-2:0], md_ge};
      end
      ftms_pkg::OP_STORE: begin
        mean_q[cmd.trait] <= mdiv[X_W-1:0];
        sd_q[cmd.trait]   <= root;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_data.mean_mut_a  <= ftms_pkg::FIELD_W'(mean_q[0]);
      res_data.sd_mut_a    <= ftms_pkg::FIELD_W'(sd_q[0]);
      res_data.mean_mut_b  <= ftms_pkg::FIELD_W'(mean_q[1]);
      res_data.sd_mut_b    <= ftms_pkg::FIELD_W'(sd_q[1]);
      res_data.mean_switch <= ftms_pkg::FIELD_W'(mean_q[2]);
      res_data.sd_switch   <= ftms_pkg::FIELD_W'(sd_q[2]);
      res_data.mean_env    <= ftms_pkg::FIELD_W'(mean_q[3]);
      res_data.sd_env      <= ftms_pkg::FIELD_W'(sd_q[3]);
      res_data.overflowed  <= overflow_flag;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("record count past maximum");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ftms_pkg::OP_DIV) |-> (div_hi < nn))
    else $error("variance quotient does not fit");

endmodule
